@@ hw/rtl/ise_pkg.sv @@
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants for the insertion sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

  // Element width follows the fixed payload field width.
  localparam int DATA_WIDTH = 16;
  localparam int MAX_ITEMS_DEF = 16;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  is_last;
  } item_t;

  typedef struct packed {
    data_t            sorted_value;
    logic [CNT_W-1:0] op_count;
    logic             overflowed;
    logic             last_out;
  } result_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;      // new key enters the chain
    logic shift_left;  // chain drains toward cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ise_cell.sv @@
// ----------------------------------------------------------------------------
// ise_cell
// One slot of the sorting chain: holds one element, compares it to the
// broadcast key, and takes from its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_cell (
  input  wire logic               clk,
  input  wire ise_pkg::data_t     key,
  input  wire ise_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               prev_occupied,
  input  wire logic               left_gt,
  input  wire ise_pkg::data_t     left_data,
  input  wire ise_pkg::data_t     right_data,
  output ise_pkg::data_t          data,
  output logic                    gt
);
  import ise_pkg::*;

  data_t take_val;
  logic  take;

  // Occupied and strictly greater: this entry moves up one slot.
  always_comb begin
    gt       = occupied && (data > key);
    take     = gt || (!occupied && prev_occupied);
    take_val = left_gt ? left_data : key;
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (take) begin
        data <= take_val;
      end
    end else if (ctrl.shift_left) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/insertion_sort_engine.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Streaming insertion sorter built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage: send signed elements as item beats, marking the final one of a set
// with is_last. On each accepted beat the key is broadcast to all
// MAX_ITEMS cells, every occupied cell holding a strictly greater value
// moves up one slot, and the key drops into the gap, so equal values keep
// arrival order. A set closes on is_last, or when the chain becomes full
// (the beat that fills it is then treated as last and every result of the
// set has overflowed set). After a set closes, item_ready stays low: a
// settle state while the operation count lands, then the chain drains from
// cell 0, one result beat per cycle while result_ready is high, last_out on
// the final beat, then the block returns to filling. op_count is moves
// plus placements (inversions plus the set size), saturating at 255, and is
// the same on every beat of the set. New items are taken again once the
// drain state sees the chain empty after the final result enters the
// output register, whether or not that beat has been taken yet.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine #(
  parameter int MAX_ITEMS = ise_pkg::MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ise_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ise_pkg::result_t      result
);
  import ise_pkg::*;

  localparam int FILL_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [FILL_W-1:0] FULL_LVL = FILL_W'(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_FILL  = 3'b001,   // taking items
    ST_SETTLE = 3'b010,  // last count update lands
    ST_DRAIN = 3'b100    // emitting sorted set
  } state_t;

  state_t state;

  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  running_count;
  logic [FILL_W-1:0] pend_shifts;
  logic              pend_valid;
  logic              overflow;

  cell_ctrl_t ctrl;
  logic       item_acc;
  logic       out_acc;
  logic       load;

  data_t cell_data [MAX_ITEMS];
  logic  [MAX_ITEMS-1:0] cell_gt;
  logic  [MAX_ITEMS-1:0] occ;

  logic [IDX_W-1:0]  pos;
  logic              any_gt;
  logic [FILL_W-1:0] shifts;
  logic [SUM_W-1:0]  cnt_sum;
  logic              close_set;

  assign item_ready = (state == ST_FILL);
  assign item_acc   = item_valid && item_ready;
  assign out_acc    = result_valid && result_ready;
  assign load       = (state == ST_DRAIN) && (fill != '0) && (!result_valid || result_ready);

  assign ctrl.insert     = item_acc;
  assign ctrl.shift_left = load;

  // --------------------------------------------------------------------------
  // Cell chain. Occupancy is a thermometer derived from the fill level.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t ld;
    data_t rd;
    logic  lgt;
    logic  pocc;

    assign occ[i] = (fill > FILL_W'(i));

    if (i == 0) begin : g_head
      assign ld   = item.value;
      assign lgt  = 1'b0;
      assign pocc = 1'b1;
    end else begin : g_body
      assign ld   = cell_data[i-1];
      assign lgt  = cell_gt[i-1];
      assign pocc = occ[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rd = cell_data[i];
    end else begin : g_mid
      assign rd = cell_data[i+1];
    end

    ise_cell u_cell (
      .clk           (clk),
      .key           (item.value),
      .ctrl          (ctrl),
      .occupied      (occ[i]),
      .prev_occupied (pocc),
      .left_gt       (lgt),
      .left_data     (ld),
      .right_data    (rd),
      .data          (cell_data[i]),
      .gt            (cell_gt[i])
    );
  end

  // --------------------------------------------------------------------------
  // Move count: the greater cells form one run ending at the fill level, so
  // its start (a one-hot edge) gives the count as fill - start.
  // --------------------------------------------------------------------------
  always_comb begin
    pos    = '0;
    any_gt = 1'b0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (cell_gt[i] && !((i > 0) && cell_gt[(i > 0) ? i - 1 : 0])) begin
        pos = pos | IDX_W'(i);
      end
      any_gt = any_gt | cell_gt[i];
    end
    shifts = any_gt ? (fill - FILL_W'(pos)) : '0;
  end

  // Placement counts one, moves add pend_shifts; clamp at the ceiling.
  assign cnt_sum   = {1'b0, running_count} + SUM_W'(pend_shifts) + SUM_W'(1);
  assign close_set = item.is_last || ((fill + FILL_W'(1)) == FULL_LVL);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      fill          <= '0;
      running_count <= '0;
      pend_valid    <= 1'b0;
      overflow      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      pend_valid <= item_acc;
      if (pend_valid) begin
        running_count <= cnt_sum[SUM_W-1] ? CNT_SAT : cnt_sum[CNT_W-1:0];
      end

      if (load) begin
        result_valid <= 1'b1;
        fill         <= fill - FILL_W'(1);
      end else if (out_acc) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_FILL: begin
          if (item_acc) begin
            fill <= fill + FILL_W'(1);
            if (close_set) begin
              overflow <= !item.is_last;
              state    <= ST_SETTLE;
            end
          end
        end
        ST_SETTLE: begin
          state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (fill == '0) begin
            running_count <= '0;
            state         <= ST_FILL;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      pend_shifts <= shifts;
    end
    if (load) begin
      result.sorted_value <= cell_data[0];
      result.op_count     <= running_count;
      result.overflowed   <= overflow;
      result.last_out     <= (fill == FILL_W'(1));
    end
  end

`ifndef SYNTHESIS
  // A closed set never leaves a count update pending into the drain.
  a_no_pend_in_drain: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && (state == ST_DRAIN)))
    else $error("count update pending during drain");

  // While filling, the chain always has a free cell.
  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill < FULL_LVL))
    else $error("chain full while taking items");

  // A waiting result beat holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("result beat changed while waiting");
`endif

endmodule

`default_nettype wire

@@ verif/insertion_sort_engine_tb.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_engine_tb
// Self-checking bench for the streaming insertion sorter. Item beats go in
// on a valid/ready channel with random gaps. A local model keeps each set in
// ascending order, counts moves plus placements, and queues the sorted
// beats that every closing item should release. Each result beat is
// checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
module insertion_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ise_pkg::*;

  localparam int SET_CAP     = MAX_ITEMS_DEF;
  localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
  localparam int IDLE_PCT    = 23;
  localparam int TAIL_CYCLES = 3 * SET_CAP;
  localparam data_t VAL_MIN  = 16'sh8000;
  localparam data_t VAL_MAX  = 16'sh7FFF;

  // How the values of one random set are drawn.
  typedef enum int {
    VAL_RANDOM,   // full 16-bit range
    VAL_NARROW,   // a few values near zero, so lots of ties
    VAL_EXTREME,  // only the two extremes, zero and -1
    VAL_RISING,   // already sorted, no moves
    VAL_FALLING   // reverse sorted, most moves
  } val_mode_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  insertion_sort_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sort model: the current set kept in ascending order, its op count, and
  // the sorted beats still owed by the block.
  // --------------------------------------------------------------------------
  data_t            sort_chain[$];
  logic [CNT_W-1:0] set_ops;
  result_t          sorted_expect[$];
  int               fail_count;
  bit               steady;        // no gaps on either side while set

  // Insert one accepted key. Strictly greater entries move up (one op each),
  // so ties keep arrival order; the placement itself is one more op.
  function automatic void sort_insert(item_t beat);
    int      pos;
    bit      close_set;
    bit      spill;
    result_t res;
    pos = sort_chain.size();
    while (pos > 0 && sort_chain[pos-1] > beat.value) begin
      pos--;
      if (set_ops != CNT_SAT) set_ops++;
    end
    sort_chain.insert(pos, beat.value);
    if (set_ops != CNT_SAT) set_ops++;

    // A full chain without is_last closes the set anyway, flagged as spilled.
    close_set = beat.is_last;
    spill     = 1'b0;
    if (!close_set && sort_chain.size() >= SET_CAP) begin
      close_set = 1'b1;
      spill     = 1'b1;
    end
    if (!close_set) return;

    foreach (sort_chain[k]) begin
      res.sorted_value = sort_chain[k];
      res.op_count     = set_ops;
      res.overflowed   = spill;
      res.last_out     = (k == sort_chain.size() - 1);
      sorted_expect.push_back(res);
    end
    sort_chain.delete();
    set_ops = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: one process sees both channels at the rising edge. The result
  // side is checked before the item side is folded into the model.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, result);
          fail_count++;
        end else begin
          want = sorted_expect.pop_front();
          if (result.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, want.sorted_value, result.sorted_value);
            fail_count++;
          end
          if (result.op_count !== want.op_count) begin
            $display("%0t: op_count expected %0d actual %0d",
                     $time, want.op_count, result.op_count);
            fail_count++;
          end
          if (result.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b",
                     $time, want.overflowed, result.overflowed);
            fail_count++;
          end
          if (result.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b actual %0b",
                     $time, want.last_out, result.last_out);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) sort_insert(item);
    end
  end

  // Receiver: backpressure about a quarter of the time, none while steady.
  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a hung handshake on both sides ends the run.
  int stall_cycles;
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("insertion_sort_engine_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Tasks are entered and left at a falling edge; valid stays
  // high between back-to-back beats and only drops for a gap or a pause.
  // --------------------------------------------------------------------------
  task automatic send_item(input data_t val, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{value: val, is_last: last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off until every owed result beat has been taken.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic data_t pick_value(val_mode_t mode, int idx);
    case (mode)
      VAL_NARROW:  return data_t'(int'($urandom_range(8)) - 4);
      VAL_EXTREME: begin
        case ($urandom_range(3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      VAL_RISING:  return data_t'(-32768 + idx * 4096 + int'($urandom_range(100)));
      VAL_FALLING: return data_t'(32767 - idx * 4096 - int'($urandom_range(100)));
      default:     return data_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Full chain closed by is_last on the very beat that fills it: no spill.
  // Reverse order with both extremes and two tied pairs, so nearly every
  // insert moves the whole chain but ties add no moves.
  task automatic test_exact_fill();
    data_t vals[SET_CAP] = '{VAL_MAX, 16'sd32766, 16'sd16384, 16'sd1000,
                             16'sd255, 16'sd1, 16'sd0, 16'sd0,
                             -16'sd1, -16'sd2, -16'sd256, -16'sd16384,
                             -16'sd16384, -16'sd30000, -16'sd32767, VAL_MIN};
    for (int k = 0; k < SET_CAP; k++) send_item(vals[k], k == SET_CAP - 1);
    wait_drained();
  endtask

  // Chain fills with no is_last: the filling beat closes the set with the
  // spill flag, and the next beat opens a new set.
  task automatic test_overflow_restart();
    for (int k = 0; k < SET_CAP; k++)
      send_item(data_t'((k % 2) ? 16'hAAAA - k : 16'h5555 + k), 1'b0);
    send_item(VAL_MIN, 1'b1);    // one-element set right after the spill
    send_item(VAL_MAX, 1'b1);
    wait_drained();
  endtask

  // Random sets: mostly short, some near or at capacity, some spilling.
  // A stretch in the middle runs with no gaps at all.
  task automatic test_random_sets(input int item_goal);
    int        sent;
    int        set_len;
    int        roll;
    bit        close_set;
    val_mode_t mode;
    sent = 0;
    while (sent < item_goal) begin
      roll = $urandom_range(99);
      mode = val_mode_t'($urandom_range(4));
      close_set = 1'b1;
      if (roll < 8) begin
        set_len   = SET_CAP;
        close_set = 1'b0;
      end else if (roll < 14) begin
        set_len = SET_CAP;
      end else if (roll < 30) begin
        set_len = $urandom_range(9, SET_CAP - 1);
      end else begin
        set_len = $urandom_range(1, 8);
      end
      steady = (sent >= 150 && sent < 260);
      for (int k = 0; k < set_len; k++)
        send_item(pick_value(mode, k), close_set && k == set_len - 1);
      sent += set_len;
      if ($urandom_range(9) == 0) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    steady       = 1'b0;
    set_ops      = '0;
    fail_count   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_exact_fill();
    test_overflow_restart();
    test_random_sets(440);

    // Anything extra the block emits now shows up as an unexpected beat.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("insertion_sort_engine_tb: clean");
    end else begin
      $display("insertion_sort_engine_tb: errors");
    end
    $finish;
  end

endmodule
